// ===== src/drt_pkg.sv =====
// shared types and constants for the dma region table
package drt_pkg;

    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [1:0] CMD_WINDOW_SET = 2'd2;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;

    localparam logic [2:0] ST_STORED     = 3'd0;
    localparam logic [2:0] ST_NO_HOST    = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_REMOVED    = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [2:0] ST_WINDOW_SET = 3'd5;

    localparam int ADDR_W = 64;

    // one table entry as stored in the region memory
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] length;
        logic [ADDR_W-1:0] host;
    } region_t;

    localparam int REGION_W = 3 * ADDR_W;

endpackage

// ===== src/dma_region_table_with_window_teardown.sv =====
// dma region table with outbound window teardown, top level
//
// one command transaction at a time: present command and operands with start
// while busy is low. busy rises the next cycle and stays high until the result
// strobe, which carries status, slot, entry_total, active_windows and
// torn_windows for exactly one cycle; the receiver cannot stall it.
// register, window-set and the unused command go straight from idle to the done
// state, and the strobe is registered from it; the next transaction can be
// accepted once busy has fallen after the strobe.
// unregister reads the region memory one entry per cycle: the search, then the
// check of every window against the found region, then the compaction (one
// read and one write per cycle), then the done state; a search that finds no
// entry goes straight to the done state. the single read port of the region
// memory is why the search and the compaction read one entry at a time.
// table entries past the fill count are never read, so the region memory needs
// no clearing pass; window enables live in flip-flops cleared at reset.
// after reset the table is empty and all windows are unmapped.
module dma_region_table_with_window_teardown #(
    parameter int TABLE_DEPTH  = 16,
    parameter int WINDOW_COUNT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [63:0] base_address,
    input  logic [63:0] length,
    input  logic [63:0] host_address,
    input  logic [2:0]  window_index,
    input  logic        window_enable,
    output logic        done,
    output logic [2:0]  status,
    output logic [3:0]  slot,
    output logic [4:0]  entry_total,
    output logic [7:0]  active_windows,
    output logic [7:0]  torn_windows
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int WW = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_WIN    = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  cmd_reg;
    logic [63:0] base_reg, len_reg, host_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;       // read pointer
    logic [AW-1:0] hit_reg, hit_next;
    logic [WW:0]   w_reg, w_next;
    logic          rd_pend_reg, rd_pend_next; // read issued last cycle
    logic [63:0] win_base_reg [WINDOW_COUNT];
    logic [63:0] win_size_reg [WINDOW_COUNT];
    logic [WINDOW_COUNT-1:0] mapped_reg, mapped_next, torn_reg, torn_next;
    logic [2:0]  status_reg, status_next;
    logic        done_reg;
    logic [AW-1:0] slot_reg;

    logic          accept;
    logic          win_sel_ok;
    assign accept     = start && !busy;
    assign win_sel_ok = int'(window_index) < WINDOW_COUNT;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    drt_pkg::region_t wr_data, rd_data;

    drt_ram #(.WIDTH(drt_pkg::REGION_W), .DEPTH(TABLE_DEPTH)) u_region (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // containment check of the current window against the found region
    logic [WW-1:0] w_idx;
    logic [64:0]   win_end, reg_end;
    logic          contained;
    assign w_idx   = w_reg[WW-1:0];
    assign win_end = {1'b0, win_base_reg[w_idx]} + {1'b0, win_size_reg[w_idx]};
    assign reg_end = {1'b0, base_reg} + {1'b0, len_reg};
    assign contained = mapped_reg[w_idx] && (win_base_reg[w_idx] >= base_reg)
                       && (win_end <= reg_end);

    logic match;
    assign match = rd_data.base == base_reg && rd_data.length == len_reg
                   && rd_data.host == host_reg;

    // register command writes in S_DONE; status tells whether it was stored
    logic reg_write;
    assign reg_write = state_reg == S_DONE && cmd_reg == drt_pkg::CMD_REGISTER
                       && status_reg == drt_pkg::ST_STORED;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        w_next       = w_reg;
        rd_pend_next = 1'b0;
        mapped_next  = mapped_reg;
        torn_next    = torn_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        wr_addr      = AW'(count_reg);
        wr_data      = '{base: base_reg, length: len_reg, host: host_reg};
        rd_addr      = idx_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next     = '0;
                    torn_next    = '0;
                    state_next   = S_DONE;
                    if (command == drt_pkg::CMD_UNREGISTER)
                    begin
                        state_next = S_SEARCH;
                    end
                    if (command == drt_pkg::CMD_WINDOW_SET && win_sel_ok)
                    begin
                        mapped_next[WW'(window_index)] = window_enable;
                    end
                end
            end
            S_SEARCH:
            begin
                if (rd_pend_reg && match)
                begin
                    hit_next   = AW'(idx_reg - CW'(1));
                    w_next     = '0;
                    state_next = S_WIN;
                end
                else if (idx_reg >= count_reg)
                begin
                    status_next = drt_pkg::ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + CW'(1);
                end
            end
            S_WIN:
            begin
                if (w_reg == (WW+1)'(WINDOW_COUNT))
                begin
                    idx_next   = CW'(hit_reg) + CW'(1);
                    hit_next   = hit_reg;
                    state_next = S_SHIFT;
                end
                else
                begin
                    if (contained)
                    begin
                        mapped_next[w_idx] = 1'b0;
                        torn_next[w_idx]   = 1'b1;
                    end
                    w_next = w_reg + (WW+1)'(1);
                end
            end
            S_SHIFT:
            begin
                // hit_reg is the write pointer, idx_reg the read pointer
                if (rd_pend_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = hit_reg;
                    wr_data  = rd_data;
                    hit_next = hit_reg + AW'(1);
                end
                if (idx_reg < count_reg)
                begin
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + CW'(1);
                end
                else if (!rd_pend_reg)
                begin
                    // tail entry is past the new count and never read again
                    count_next  = count_reg - CW'(1);
                    status_next = drt_pkg::ST_REMOVED;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
                if (reg_write)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = AW'(count_reg);
                    count_next = count_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            w_reg       <= '0;
            mapped_reg  <= '0;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
            status_reg  <= drt_pkg::ST_STORED;
            hit_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            w_reg       <= w_next;
            mapped_reg  <= mapped_next;
            rd_pend_reg <= rd_pend_next;
            done_reg    <= (state_reg == S_DONE);
            if (state_reg == S_IDLE && accept)
            begin
                unique case (command)
                    drt_pkg::CMD_REGISTER:
                    begin
                        if (host_address == 64'd0)
                        begin
                            status_reg <= drt_pkg::ST_NO_HOST;
                        end
                        else if (count_reg >= CW'(TABLE_DEPTH))
                        begin
                            status_reg <= drt_pkg::ST_FULL;
                        end
                        else
                        begin
                            status_reg <= drt_pkg::ST_STORED;
                            hit_reg    <= AW'(count_reg);
                        end
                    end
                    drt_pkg::CMD_WINDOW_SET:
                    begin
                        status_reg <= drt_pkg::ST_WINDOW_SET;
                    end
                    default:
                    begin
                        status_reg <= drt_pkg::ST_NOT_FOUND;
                    end
                endcase
                if (command != drt_pkg::CMD_REGISTER)
                begin
                    hit_reg <= '0;
                end
            end
            else
            begin
                status_reg <= status_next;
                hit_reg    <= hit_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            torn_reg <= '0;
        end
        else
        begin
            torn_reg <= torn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            cmd_reg  <= command;
            base_reg <= base_address;
            len_reg  <= length;
            host_reg <= host_address;
            if (command == drt_pkg::CMD_WINDOW_SET && win_sel_ok)
            begin
                win_base_reg[WW'(window_index)] <= base_address;
                win_size_reg[WW'(window_index)] <= length;
            end
        end
    end

    assign busy           = state_reg != S_IDLE || done_reg;
    assign done           = done_reg;
    assign status         = status_reg;
    assign slot           = (status_reg == drt_pkg::ST_STORED ||
                             status_reg == drt_pkg::ST_REMOVED) ? 4'(slot_reg) : 4'd0;
    assign entry_total    = 5'(count_reg);
    assign active_windows = 8'(mapped_reg);
    assign torn_windows   = (status_reg == drt_pkg::ST_REMOVED) ? 8'(torn_reg) : 8'd0;

    // slot latched when the result is formed
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WIN && w_reg == '0)
        begin
            slot_reg <= hit_reg;
        end
        else if (reg_write)
        begin
            slot_reg <= AW'(count_reg);
        end
    end

endmodule

// ===== src/drt_ram.sv =====
// generic single-port-write ram with one registered read port
module drt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== tb/region_table_checker.sv =====
// checker: predicts the region table and window mask and compares each result
`timescale 1ns / 1ps

module region_table_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  command,
    input  logic [63:0] base_address,
    input  logic [63:0] length,
    input  logic [63:0] host_address,
    input  logic [2:0]  window_index,
    input  logic        window_enable,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic [3:0]  slot,
    input  logic [4:0]  entry_total,
    input  logic [7:0]  active_windows,
    input  logic [7:0]  torn_windows,
    output int          errors,
    output int          pending
);

    localparam int DEPTH = 16;
    localparam int WINDOWS = 8;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot;
        logic [4:0] entry_total;
        logic [7:0] active_windows;
        logic [7:0] torn_windows;
    } outcome_t;

    drt_pkg::region_t regions [DEPTH];
    logic [4:0]  fill;
    logic [63:0] win_base [WINDOWS];
    logic [63:0] win_size [WINDOWS];
    logic [7:0]  win_mask;
    outcome_t    expected_outcomes [$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic clear_table();
        for (int i = 0; i < DEPTH; i++)
            regions[i] = '0;
        for (int w = 0; w < WINDOWS; w++)
        begin
            win_base[w] = '0;
            win_size[w] = '0;
        end
        fill = '0;
        win_mask = '0;
    endtask

    // one command against the shadow table
    task automatic apply_command(output outcome_t o);
        int hit;
        o = '0;
        o.status = drt_pkg::ST_NOT_FOUND;
        if (command == drt_pkg::CMD_REGISTER)
        begin
            if (host_address == '0)
                o.status = drt_pkg::ST_NO_HOST;
            else if (fill >= DEPTH)
                o.status = drt_pkg::ST_FULL;
            else
            begin
                regions[fill] = '{base: base_address, length: length, host: host_address};
                o.slot = fill[3:0];
                fill++;
                o.status = drt_pkg::ST_STORED;
            end
        end
        else if (command == drt_pkg::CMD_UNREGISTER)
        begin
            hit = -1;
            for (int i = 0; i < DEPTH; i++)
                if (hit < 0 && i < fill && regions[i].base == base_address
                    && regions[i].length == length && regions[i].host == host_address)
                    hit = i;
            if (hit >= 0)
            begin
                for (int w = 0; w < WINDOWS; w++)
                    // 65-bit end points so the sums never wrap
                    if (win_mask[w] && win_base[w] >= regions[hit].base
                        && ({1'b0, win_base[w]} + {1'b0, win_size[w]})
                           <= ({1'b0, regions[hit].base} + {1'b0, regions[hit].length}))
                    begin
                        win_mask[w] = 1'b0;
                        o.torn_windows[w] = 1'b1;
                    end
                for (int k = hit; k + 1 < fill; k++)
                    regions[k] = regions[k + 1];
                fill--;
                regions[fill] = '0;
                o.slot = hit[3:0];
                o.status = drt_pkg::ST_REMOVED;
            end
        end
        else if (command == drt_pkg::CMD_WINDOW_SET)
        begin
            win_base[window_index] = base_address;
            win_size[window_index] = length;
            win_mask[window_index] = window_enable;
            o.status = drt_pkg::ST_WINDOW_SET;
        end
        o.entry_total = fill;
        o.active_windows = win_mask;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        outcome_t want;
        if (!rst_n)
        begin
            clear_table();
            expected_outcomes.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_command(o);
                expected_outcomes.push_back(o);
            end
            if (done)
            begin
                if (expected_outcomes.size() == 0)
                    report("unexpected result, status", status, 0);
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (status !== want.status)
                        report("status", status, want.status);
                    if (slot !== want.slot)
                        report("slot", slot, want.slot);
                    if (entry_total !== want.entry_total)
                        report("entry_total", entry_total, want.entry_total);
                    if (active_windows !== want.active_windows)
                        report("active_windows", active_windows, want.active_windows);
                    if (torn_windows !== want.torn_windows)
                        report("torn_windows", torn_windows, want.torn_windows);
                end
            end
            pending = expected_outcomes.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// testbench top: command stimulus for the dma region table and the verdict
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam logic [63:0] ONES = '1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  command = drt_pkg::CMD_REGISTER;
    logic [63:0] base_address = '0;
    logic [63:0] length = '0;
    logic [63:0] host_address = '0;
    logic [2:0]  window_index = '0;
    logic        window_enable = 1'b0;
    logic        done;
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [4:0]  entry_total;
    logic [7:0]  active_windows;
    logic [7:0]  torn_windows;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          idle_pct = 0;

    // regions handed to register commands, used to build matching unregisters
    logic [63:0] known_base [$];
    logic [63:0] known_len [$];
    logic [63:0] known_host [$];

    dma_region_table_with_window_teardown dut (.*);

    region_table_checker u_checker (.*);

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL dma_region_table_with_window_teardown");
            $finish;
        end
    end

    task automatic issue(input logic [1:0] cmd, input logic [63:0] b, input logic [63:0] l,
                         input logic [63:0] h, input logic [2:0] wi, input logic we);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        base_address <= b;
        length <= l;
        host_address <= h;
        window_index <= wi;
        window_enable <= we;
        do
            @(posedge clk);
        while (busy);
        if (cmd == drt_pkg::CMD_REGISTER && h != '0)
        begin
            known_base.push_back(b);
            known_len.push_back(l);
            known_host.push_back(h);
        end
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return {32'b0, $urandom};
            2: return 64'($urandom_range(4096));
            default: return ONES - 64'($urandom_range(4096));
        endcase
    endfunction

    task automatic random_transaction();
        int pick;
        int n;
        logic [63:0] rb, rl, off;
        pick = $urandom_range(99);
        n = known_base.size();
        if (pick < 40)
            issue(drt_pkg::CMD_REGISTER, rand64(), rand64(),
                  ($urandom_range(19) == 0) ? 64'd0 : rand64(), 3'($urandom), 1'($urandom));
        else if (pick < 68 && n > 0)
        begin
            n = $urandom_range(n - 1);
            rb = known_base[n];
            rl = known_len[n];
            // mostly the exact triple, sometimes one field off
            case ($urandom_range(9))
                0: issue(drt_pkg::CMD_UNREGISTER, rb ^ 64'd1, rl, known_host[n], 3'($urandom),
                         1'($urandom));
                1: issue(drt_pkg::CMD_UNREGISTER, rb, rl, known_host[n] + 64'd1, 3'd0, 1'b0);
                default:
                begin
                    issue(drt_pkg::CMD_UNREGISTER, rb, rl, known_host[n], 3'($urandom),
                          1'($urandom));
                    known_base.delete(n);
                    known_len.delete(n);
                    known_host.delete(n);
                end
            endcase
        end
        else if (pick < 95)
        begin
            if (n > 0 && $urandom_range(3) != 0)
            begin
                n = $urandom_range(n - 1);
                rb = known_base[n];
                rl = known_len[n];
                off = {32'b0, $urandom} % (rl / 2 + 1);
                case ($urandom_range(3))
                    0: issue(drt_pkg::CMD_WINDOW_SET, rb, rl, rand64(), 3'($urandom), 1'b1);
                    1: issue(drt_pkg::CMD_WINDOW_SET, rb + off, rl - off + 64'd1, rand64(),
                             3'($urandom), 1'($urandom));
                    default: issue(drt_pkg::CMD_WINDOW_SET, rb + off,
                                   {32'b0, $urandom} % (rl / 2 + 1),
                                   rand64(), 3'($urandom), $urandom_range(4) != 0);
                endcase
            end
            else
                issue(drt_pkg::CMD_WINDOW_SET, rand64(), rand64(), rand64(), 3'($urandom),
                      1'($urandom));
        end
        else
            issue(drt_pkg::CMD_UNUSED, rand64(), rand64(), rand64(), 3'($urandom),
                  1'($urandom));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: refusals, wrapped region ends, containment edges, unused command
        issue(drt_pkg::CMD_REGISTER, ONES, ONES, 64'd0, 3'd7, 1'b1);
        issue(drt_pkg::CMD_UNREGISTER, 64'd0, 64'd0, 64'd0, 3'd0, 1'b0);
        issue(drt_pkg::CMD_UNUSED, ONES, ONES, ONES, 3'd7, 1'b1);
        issue(drt_pkg::CMD_REGISTER, ONES - 64'hFF, 64'h200, ONES, 3'd0, 1'b0);
        issue(drt_pkg::CMD_WINDOW_SET, ONES - 64'h7F, 64'h180, 64'd0, 3'd0, 1'b1);
        issue(drt_pkg::CMD_WINDOW_SET, ONES - 64'h7F, 64'h181, 64'd0, 3'd1, 1'b1);
        issue(drt_pkg::CMD_WINDOW_SET, ONES - 64'h100, 64'd1, 64'd0, 3'd2, 1'b1);
        issue(drt_pkg::CMD_WINDOW_SET, ONES, ONES, ONES, 3'd7, 1'b1);
        issue(drt_pkg::CMD_WINDOW_SET, ONES - 64'hFF, 64'd0, 64'd0, 3'd3, 1'b0);
        issue(drt_pkg::CMD_REGISTER, 64'd0, 64'd0, 64'd1, 3'd0, 1'b0);
        issue(drt_pkg::CMD_WINDOW_SET, 64'd0, 64'd0, 64'd0, 3'd4, 1'b1);
        issue(drt_pkg::CMD_UNREGISTER, ONES - 64'hFF, 64'h200, ONES - 64'd1, 3'd0, 1'b0);
        issue(drt_pkg::CMD_UNREGISTER, ONES - 64'hFF, 64'h200, ONES, 3'd0, 1'b0);
        issue(drt_pkg::CMD_UNREGISTER, 64'd0, 64'd0, 64'd1, 3'd0, 1'b0);
        issue(drt_pkg::CMD_REGISTER, 64'd0, ONES, 64'd5, 3'd0, 1'b0);
        issue(drt_pkg::CMD_WINDOW_SET, 64'd0, ONES, 64'd0, 3'd5, 1'b1);
        issue(drt_pkg::CMD_WINDOW_SET, 64'd1, ONES - 64'd1, 64'd0, 3'd6, 1'b1);
        issue(drt_pkg::CMD_UNREGISTER, 64'd0, ONES, 64'd5, 3'd0, 1'b0);
        known_base.delete();
        known_len.delete();
        known_host.delete();

        idle_pct = 29;
        repeat (430) random_transaction();
        idle_pct = 70;
        repeat (430) random_transaction();
        idle_pct = 0;
        repeat (430) random_transaction();
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS dma_region_table_with_window_teardown");
        else
            $display("FAIL dma_region_table_with_window_teardown");
        $finish;
    end

endmodule

// ===== files.f =====
src/drt_pkg.sv
src/drt_ram.sv
src/dma_region_table_with_window_teardown.sv
tb/region_table_checker.sv
tb/tb.sv
